@@ design/bba_pkg.sv @@
// Shared types, constants and the helper function of the buddy block allocator.
package bba_pkg;

   localparam int DATA_W   = 48;
   localparam int CFG_W    = 6;
   localparam int STATUS_W = 3;

   typedef enum logic [1:0] {
      OP_ALLOC       = 2'd0,
      OP_FREE        = 2'd1,
      OP_ALIGN_ALLOC = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NO_BLOCK  = 3'd1,
      ST_TOO_LARGE = 3'd2,
      ST_BAD_ALIGN = 3'd3,
      ST_UNKNOWN   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_HEAP_ORDER = 2'd0,
      CSR_MIN_ORDER  = 2'd1,
      CSR_HEAP_BASE  = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_DECODE,
      S_SRCH_RD,
      S_SRCH_CHK,
      S_SPLIT_RD,
      S_SPLIT_WR,
      S_TAG_WR,
      S_FTAG_RD,
      S_FTAG_CHK,
      S_MERGE_RD,
      S_MERGE_CHK,
      S_DONE
   } state_type;

   // Round up to the next power of two and return its log2.
   function automatic logic [CFG_W-1:0] ceil_log2(input logic [DATA_W-1:0] v);
      logic [CFG_W-1:0] hi;
      logic             not_pow2;
      hi = '0;
      for (int i = 0; i < DATA_W; i++) begin
         if (v[i]) begin
            hi = CFG_W'(i);
         end
      end
      not_pow2 = ((v & (v - DATA_W'(1))) != '0);
      return hi + CFG_W'(not_pow2);
   endfunction

endpackage

@@ design/bba_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
module bba_ram #(
   parameter int ADDR_W = 4,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/buddy_block_allocator_top.sv @@
// Binary buddy allocator over a 2^heap_order byte heap at heap_base. One request is
// worked at a time. Allocate scans rows of 32 free bits at the chosen level, splits
// down one level per split step and writes the order tag. Free checks the order tag and
// merges upward; every split or merge step is a read and a write-back of one row of the
// free-bit RAM. A request rejected at decode, or a free with no valid tag, goes straight
// to the result. A result waits in S_DONE while an earlier one is held for rsp_ready.
// After reset and after every write to a configuration register the block clears the
// free-bit and order-tag RAMs, and accepts no request meanwhile. A finished result sits
// in the output register while the next request is taken.
module buddy_block_allocator_top #(
   parameter int TREE_DEPTH = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_op,
   input  logic [bba_pkg::DATA_W-1:0]   req_size,
   input  logic [bba_pkg::DATA_W-1:0]   req_align,
   input  logic [bba_pkg::DATA_W-1:0]   req_address,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bba_pkg::STATUS_W-1:0] rsp_status,
   output logic [bba_pkg::DATA_W-1:0]   rsp_address_res,
   output logic [bba_pkg::CFG_W-1:0]    rsp_order,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [bba_pkg::DATA_W-1:0]   csr_wdata
);

   localparam int DW    = bba_pkg::DATA_W;
   localparam int OW    = bba_pkg::CFG_W;
   localparam int LW    = $clog2(TREE_DEPTH + 1);
   localparam int NLVL  = TREE_DEPTH + 1;
   localparam int NBLK  = 1 << TREE_DEPTH;
   localparam int BW    = (TREE_DEPTH >= 5) ? 5 : TREE_DEPTH;
   localparam int WORD  = 1 << BW;
   localparam int RB    = (TREE_DEPTH > BW) ? TREE_DEPTH - BW : 1;
   localparam int AW    = LW + RB;
   localparam int TW    = LW + 1;
   localparam int CW    = TREE_DEPTH + 1;
   localparam int SWB   = (AW > TREE_DEPTH) ? AW : TREE_DEPTH;

   bba_pkg::state_type state_ff, state_in;

   logic [OW-1:0]  heap_order_ff, min_order_ff;
   logic [DW-1:0]  heap_base_ff;
   logic           cfg_wr;

   logic [1:0]     op_ff;
   logic [DW-1:0]  size_ff, align_ff, addr_ff;
   logic [OW-1:0]  ord_ff, ord_in;
   logic [LW-1:0]  r_ff, r_in, lvl_ff, lvl_in;
   logic [TREE_DEPTH-1:0] seg_ff, seg_in, idx_ff, idx_in;
   logic [RB-1:0]  row_ff, row_in;
   logic [SWB-1:0] sw_cnt_ff;
   logic [CW-1:0]  cnt_ff [NLVL];
   logic [CW-1:0]  cnt_in [NLVL];

   logic [bba_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [DW-1:0]  res_addr_ff, res_addr_in;
   logic [OW-1:0]  res_order_ff, res_order_in;

   logic           rsp_valid_ff;
   logic [bba_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [DW-1:0]  rsp_addr_ff;
   logic [OW-1:0]  rsp_order_ff;

   // free-bit and tag RAM ports
   logic           fb_we, tg_we;
   logic [AW-1:0]  fb_waddr, fb_raddr;
   logic [WORD-1:0] fb_wdata, fb_rdata;
   logic [TREE_DEPTH-1:0] tg_waddr;
   logic [TW-1:0]  tg_wdata, tg_rdata;

   // derived configuration
   logic [OW-1:0]  emin;
   logic [LW-1:0]  top_lvl;

   // decode terms
   logic [OW-1:0]  size_ord, align_ord, ord_sel, ord_raise;
   logic           align_bad, too_big, lvl_found;
   logic [LW-1:0]  r_req, ro_sel;
   logic [DW-1:0]  off, idx_full;
   logic           off_bad;
   logic [BW-1:0]  low_bit;
   logic [TREE_DEPTH-1:0] seg_up;
   logic [LW-1:0]  tag_lvl;

   assign cfg_wr = csr_we && (csr_index inside {bba_pkg::CSR_HEAP_ORDER,
                                                bba_pkg::CSR_MIN_ORDER,
                                                bba_pkg::CSR_HEAP_BASE});

   always_comb begin
      emin = min_order_ff;
      if (heap_order_ff > OW'(TREE_DEPTH) && heap_order_ff - OW'(TREE_DEPTH) > min_order_ff) begin
         emin = heap_order_ff - OW'(TREE_DEPTH);
      end
      top_lvl = (heap_order_ff > emin) ? LW'(heap_order_ff - emin) : '0;
   end

   always_comb begin
      size_ord  = bba_pkg::ceil_log2(size_ff);
      align_ord = bba_pkg::ceil_log2(align_ff);
      align_bad = (align_ff == '0) || ((align_ff & (align_ff - DW'(1))) != '0);
      ord_sel   = size_ord;
      if (op_ff != bba_pkg::OP_ALLOC &&
          {1'b0, align_ff} > ((DW + 1)'(1) << size_ord)) begin
         ord_sel = align_ord;
      end
      ord_raise = (ord_sel < emin) ? emin : ord_sel;
      too_big   = ord_raise > heap_order_ff;
      r_req     = LW'(ord_raise - emin);
      lvl_found = 1'b0;
      ro_sel    = '0;
      // descend so that the lowest sufficient level wins
      for (int l = NLVL - 1; l >= 0; l--) begin
         if (LW'(l) >= r_req && LW'(l) <= top_lvl && cnt_ff[l] != '0) begin
            lvl_found = 1'b1;
            ro_sel    = LW'(l);
         end
      end
      off      = addr_ff - heap_base_ff;
      idx_full = off >> emin;
      off_bad  = (emin > heap_order_ff) || ((off >> heap_order_ff) != '0) ||
                 ((off & ((DW'(1) << emin) - DW'(1))) != '0) ||
                 (idx_full >= DW'(NBLK));
      low_bit  = '0;
      for (int b = WORD - 1; b >= 0; b--) begin
         if (fb_rdata[b]) begin
            low_bit = BW'(b);
         end
      end
      seg_up  = seg_ff << 1;
      tag_lvl = tg_rdata[LW-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      ord_in        = ord_ff;
      r_in          = r_ff;
      lvl_in        = lvl_ff;
      seg_in        = seg_ff;
      idx_in        = idx_ff;
      row_in        = row_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_order_in  = res_order_ff;
      cnt_in        = cnt_ff;
      fb_we         = 1'b0;
      fb_waddr      = {lvl_ff, RB'(seg_ff >> BW)};
      fb_wdata      = fb_rdata;
      fb_raddr      = {lvl_ff, RB'(seg_ff >> BW)};
      tg_we         = 1'b0;
      tg_waddr      = idx_ff;
      tg_wdata      = '0;
      req_ready     = 1'b0;

      case (state_ff)
         bba_pkg::S_SWEEP: begin
            fb_we    = 1'b1;
            fb_waddr = sw_cnt_ff[AW-1:0];
            fb_wdata = (sw_cnt_ff[AW-1:0] == {top_lvl, RB'(0)}) ? WORD'(1) : '0;
            tg_we    = 1'b1;
            tg_waddr = sw_cnt_ff[TREE_DEPTH-1:0];
            if (&sw_cnt_ff) begin
               for (int l = 0; l < NLVL; l++) begin
                  cnt_in[l] = (LW'(l) == top_lvl) ? CW'(1) : '0;
               end
               state_in = bba_pkg::S_IDLE;
            end
         end
         bba_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = bba_pkg::S_DECODE;
            end
         end
         bba_pkg::S_DECODE: begin
            res_addr_in  = '0;
            res_order_in = '0;
            state_in     = bba_pkg::S_DONE;
            if (op_ff == bba_pkg::OP_FREE) begin
               if (off_bad) begin
                  res_status_in = bba_pkg::ST_UNKNOWN;
               end else begin
                  idx_in   = TREE_DEPTH'(idx_full);
                  state_in = bba_pkg::S_FTAG_RD;
               end
            end else if (op_ff != bba_pkg::OP_ALLOC && align_bad) begin
               res_status_in = bba_pkg::ST_BAD_ALIGN;
            end else if (too_big) begin
               res_status_in = bba_pkg::ST_TOO_LARGE;
            end else if (!lvl_found) begin
               res_status_in = bba_pkg::ST_NO_BLOCK;
            end else begin
               ord_in   = ord_raise;
               r_in     = r_req;
               lvl_in   = ro_sel;
               row_in   = '0;
               state_in = bba_pkg::S_SRCH_RD;
            end
         end
         bba_pkg::S_SRCH_RD: begin
            fb_raddr = {lvl_ff, row_ff};
            state_in = bba_pkg::S_SRCH_CHK;
         end
         bba_pkg::S_SRCH_CHK: begin
            if (fb_rdata != '0) begin
               fb_we          = 1'b1;
               fb_waddr       = {lvl_ff, row_ff};
               fb_wdata       = fb_rdata & ~(WORD'(1) << low_bit);
               cnt_in[lvl_ff] = cnt_ff[lvl_ff] - CW'(1);
               seg_in         = TREE_DEPTH'({row_ff, low_bit});
               state_in       = (lvl_ff == r_ff) ? bba_pkg::S_TAG_WR : bba_pkg::S_SPLIT_RD;
            end else begin
               row_in   = row_ff + RB'(1);
               state_in = bba_pkg::S_SRCH_RD;
            end
         end
         bba_pkg::S_SPLIT_RD: begin
            // descend one level; the buddy of the kept half is set free next
            fb_raddr = {lvl_ff - LW'(1), RB'(seg_up >> BW)};
            seg_in   = seg_up;
            lvl_in   = lvl_ff - LW'(1);
            state_in = bba_pkg::S_SPLIT_WR;
         end
         bba_pkg::S_SPLIT_WR: begin
            fb_we          = 1'b1;
            fb_wdata       = fb_rdata | (WORD'(1) << (seg_ff[BW-1:0] ^ BW'(1)));
            cnt_in[lvl_ff] = cnt_ff[lvl_ff] + CW'(1);
            state_in       = (lvl_ff == r_ff) ? bba_pkg::S_TAG_WR : bba_pkg::S_SPLIT_RD;
         end
         bba_pkg::S_TAG_WR: begin
            tg_we         = 1'b1;
            tg_waddr      = TREE_DEPTH'(seg_ff << r_ff);
            tg_wdata      = {1'b1, r_ff};
            res_status_in = bba_pkg::ST_OK;
            res_addr_in   = heap_base_ff + (DW'(seg_ff) << ord_ff);
            res_order_in  = ord_ff;
            state_in      = bba_pkg::S_DONE;
         end
         bba_pkg::S_FTAG_RD: begin
            state_in = bba_pkg::S_FTAG_CHK;
         end
         bba_pkg::S_FTAG_CHK: begin
            if (!tg_rdata[LW] || tag_lvl > top_lvl) begin
               res_status_in = bba_pkg::ST_UNKNOWN;
               state_in      = bba_pkg::S_DONE;
            end else begin
               tg_we    = 1'b1;
               tg_waddr = idx_ff;
               lvl_in   = tag_lvl;
               seg_in   = idx_ff >> tag_lvl;
               ord_in   = OW'(tag_lvl) + emin;
               state_in = bba_pkg::S_MERGE_RD;
            end
         end
         bba_pkg::S_MERGE_RD: begin
            state_in = bba_pkg::S_MERGE_CHK;
         end
         bba_pkg::S_MERGE_CHK: begin
            fb_we = 1'b1;
            if (lvl_ff < top_lvl && fb_rdata[seg_ff[BW-1:0] ^ BW'(1)]) begin
               // buddy is free: take it and climb
               fb_wdata       = fb_rdata & ~(WORD'(1) << (seg_ff[BW-1:0] ^ BW'(1)));
               cnt_in[lvl_ff] = cnt_ff[lvl_ff] - CW'(1);
               seg_in         = seg_ff >> 1;
               lvl_in         = lvl_ff + LW'(1);
               state_in       = bba_pkg::S_MERGE_RD;
            end else begin
               fb_wdata       = fb_rdata | (WORD'(1) << seg_ff[BW-1:0]);
               cnt_in[lvl_ff] = cnt_ff[lvl_ff] + CW'(1);
               res_status_in  = bba_pkg::ST_OK;
               res_addr_in    = addr_ff;
               res_order_in   = ord_ff;
               state_in       = bba_pkg::S_DONE;
            end
         end
         bba_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = bba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bba_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bba_pkg::S_SWEEP;
         sw_cnt_ff     <= '0;
         heap_order_ff <= OW'(20);
         min_order_ff  <= OW'(7);
         heap_base_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // a register write restarts the clearing pass
         state_ff  <= cfg_wr ? bba_pkg::S_SWEEP : state_in;
         sw_cnt_ff <= (!cfg_wr && state_ff == bba_pkg::S_SWEEP) ? sw_cnt_ff + SWB'(1) : '0;
         if (csr_we) begin
            case (csr_index)
               bba_pkg::CSR_HEAP_ORDER: begin
                  heap_order_ff <= csr_wdata[OW-1:0];
               end
               bba_pkg::CSR_MIN_ORDER: begin
                  min_order_ff <= csr_wdata[OW-1:0];
               end
               bba_pkg::CSR_HEAP_BASE: begin
                  heap_base_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (state_ff == bba_pkg::S_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == bba_pkg::S_IDLE && req_valid) begin
         op_ff    <= req_op;
         size_ff  <= req_size;
         align_ff <= req_align;
         addr_ff  <= req_address;
      end
      if (state_ff == bba_pkg::S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_order_ff  <= res_order_ff;
      end
      ord_ff        <= ord_in;
      r_ff          <= r_in;
      lvl_ff        <= lvl_in;
      seg_ff        <= seg_in;
      idx_ff        <= idx_in;
      row_ff        <= row_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_order_ff  <= res_order_in;
      cnt_ff        <= cnt_in;
   end

   bba_ram #(
      .ADDR_W(AW),
      .DATA_W(WORD)
   ) u_free_bits (
      .clock  (clock),
      .wr_en  (fb_we),
      .wr_addr(fb_waddr),
      .wr_data(fb_wdata),
      .rd_addr(fb_raddr),
      .rd_data(fb_rdata)
   );

   bba_ram #(
      .ADDR_W(TREE_DEPTH),
      .DATA_W(TW)
   ) u_order_tags (
      .clock  (clock),
      .wr_en  (tg_we),
      .wr_addr(tg_waddr),
      .wr_data(tg_wdata),
      .rd_addr(idx_ff),
      .rd_data(tg_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_address_res = rsp_addr_ff;
   assign rsp_order       = rsp_order_ff;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench of the buddy block allocator with an inline allocator predictor.
`timescale 1ns / 1ps

module testbench;

   localparam int TREE_DEPTH = 10;
   localparam int NBLK = 1 << TREE_DEPTH;
   localparam int RAND_ITEMS = 950;
   localparam int DATA_W = bba_pkg::DATA_W;
   localparam int CFG_W = bba_pkg::CFG_W;
   localparam int STATUS_W = bba_pkg::STATUS_W;

   typedef struct {
      logic [1:0]        op;
      logic [DATA_W-1:0] size;
      logic [DATA_W-1:0] align;
      logic [DATA_W-1:0] address;
   } alloc_req_type;

   typedef struct {
      bba_pkg::status_type status;
      logic [DATA_W-1:0]   address;
      logic [CFG_W-1:0]    order;
   } alloc_rsp_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [1:0]          req_op;
   logic [DATA_W-1:0]   req_size;
   logic [DATA_W-1:0]   req_align;
   logic [DATA_W-1:0]   req_address;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [DATA_W-1:0]   rsp_address_res;
   logic [CFG_W-1:0]    rsp_order;
   logic                csr_we;
   logic [1:0]          csr_index;
   logic [DATA_W-1:0]   csr_wdata;

   alloc_req_type     pending_reqs[$];
   alloc_rsp_type     expected_rsps[$];
   logic [DATA_W-1:0] live_blocks[$];
   int unsigned       send_idle_pct;
   int unsigned       recv_idle_pct;
   int unsigned       mismatch_count;
   int unsigned       sent_count;

   // allocator shadow state
   logic [5:0]        cfg_heap_order;
   logic [5:0]        cfg_min_order;
   logic [DATA_W-1:0] cfg_heap_base;
   bit                level_free[TREE_DEPTH+1][NBLK];
   int unsigned       level_count[TREE_DEPTH+1];
   logic [4:0]        block_tag[NBLK];

   buddy_block_allocator_top #(.TREE_DEPTH(TREE_DEPTH)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_size(req_size), .req_align(req_align), .req_address(req_address),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_address_res(rsp_address_res), .rsp_order(rsp_order),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
   end
   always #2 clock = ~clock;

   function automatic int unsigned eff_min_order();
      int unsigned e;
      e = 32'(cfg_min_order);
      if (cfg_heap_order > TREE_DEPTH && cfg_heap_order - TREE_DEPTH > e) begin
         e = cfg_heap_order - TREE_DEPTH;
      end
      return e;
   endfunction

   function automatic int unsigned tree_levels();
      int unsigned e;
      e = eff_min_order();
      return (cfg_heap_order > e) ? cfg_heap_order - e : 0;
   endfunction

   function automatic void clear_heap();
      for (int l = 0; l <= TREE_DEPTH; l++) begin
         level_count[l] = 0;
         for (int i = 0; i < NBLK; i++) level_free[l][i] = 1'b0;
      end
      for (int i = 0; i < NBLK; i++) block_tag[i] = '0;
      level_free[tree_levels()][0] = 1'b1;
      level_count[tree_levels()] = 1;
      live_blocks.delete();
   endfunction

   function automatic int unsigned round_up_log2(logic [63:0] v);
      int unsigned o;
      o = ((v & (v - 64'd1)) != 0) ? 1 : 0;
      while (v > 64'd1) begin
         v = v >> 1;
         o++;
      end
      return o;
   endfunction

   function automatic alloc_rsp_type failed(bba_pkg::status_type st);
      alloc_rsp_type r;
      r.status  = st;
      r.address = '0;
      r.order   = '0;
      return r;
   endfunction

   function automatic alloc_rsp_type take_block(int unsigned ord);
      int unsigned   emin, top, r, lvl, seg;
      bit            found;
      alloc_rsp_type res;
      logic [63:0]   addr;
      emin  = eff_min_order();
      top   = tree_levels();
      found = 1'b0;
      seg   = 0;
      if (ord < emin) ord = emin;
      if (ord > cfg_heap_order) return failed(bba_pkg::ST_TOO_LARGE);
      r   = ord - emin;
      lvl = r;
      while (lvl <= top && !found) begin
         if (level_count[lvl] != 0) begin
            for (int i = 0; i < (1 << (top - lvl)) && !found; i++) begin
               if (level_free[lvl][i]) begin
                  seg   = i;
                  found = 1'b1;
               end
            end
         end
         if (!found) lvl++;
      end
      if (!found) return failed(bba_pkg::ST_NO_BLOCK);
      level_free[lvl][seg] = 1'b0;
      level_count[lvl]--;
      // split down, leaving the upper half of each split free
      while (lvl > r) begin
         lvl--;
         seg = seg << 1;
         level_free[lvl][seg ^ 1] = 1'b1;
         level_count[lvl]++;
      end
      block_tag[(seg << r) & (NBLK - 1)] = 5'h10 | 5'(r);
      addr = 64'(cfg_heap_base) + (64'(seg) << ord);
      res.status  = bba_pkg::ST_OK;
      res.address = addr[DATA_W-1:0];
      res.order   = CFG_W'(ord);
      live_blocks.push_back(res.address);
      return res;
   endfunction

   function automatic alloc_rsp_type release_block(logic [DATA_W-1:0] addr);
      int unsigned       emin, top, r, seg;
      logic [DATA_W-1:0] off;
      logic [63:0]       idx;
      logic [4:0]        tag;
      alloc_rsp_type     res;
      emin = eff_min_order();
      top  = tree_levels();
      off  = addr - cfg_heap_base;
      if (emin > cfg_heap_order || (64'(off) >> cfg_heap_order) != 0 ||
          (64'(off) & ((64'd1 << emin) - 64'd1)) != 0) return failed(bba_pkg::ST_UNKNOWN);
      idx = 64'(off) >> emin;
      if (idx >= NBLK) return failed(bba_pkg::ST_UNKNOWN);
      tag = block_tag[idx];
      if (!tag[4] || tag[3:0] > top) return failed(bba_pkg::ST_UNKNOWN);
      r = 32'(tag[3:0]);
      block_tag[idx] = '0;
      seg = 32'(idx >> r);
      // merge while the buddy is free
      while (r < top && level_free[r][(seg ^ 1) & (NBLK - 1)]) begin
         level_free[r][(seg ^ 1) & (NBLK - 1)] = 1'b0;
         level_count[r]--;
         seg = seg >> 1;
         r++;
      end
      level_free[r][seg & (NBLK - 1)] = 1'b1;
      level_count[r]++;
      for (int i = 0; i < live_blocks.size(); i++) begin
         if (live_blocks[i] == addr) begin
            live_blocks.delete(i);
            break;
         end
      end
      res.status  = bba_pkg::ST_OK;
      res.address = addr;
      res.order   = CFG_W'(32'(tag[3:0]) + emin);
      return res;
   endfunction

   function automatic alloc_rsp_type predict_alloc(alloc_req_type q);
      int unsigned ord;
      if (q.op == bba_pkg::OP_ALLOC) return take_block(round_up_log2(64'(q.size)));
      if (q.op == bba_pkg::OP_FREE) return release_block(q.address);
      // aligned allocate, also for the unused op code
      if (q.align == '0 || (q.align & (q.align - DATA_W'(1))) != '0)
         return failed(bba_pkg::ST_BAD_ALIGN);
      ord = round_up_log2(64'(q.size));
      if (64'(q.align) > (64'd1 << ord)) ord = round_up_log2(64'(q.align));
      return take_block(ord);
   endfunction

   // driver
   always @(posedge clock) begin
      alloc_req_type q;
      if (reset) begin
         req_valid   <= 1'b0;
         req_op      <= '0;
         req_size    <= '0;
         req_align   <= '0;
         req_address <= '0;
      end else begin
         if (req_valid && req_ready) begin
            q.op = req_op;
            q.size = req_size;
            q.align = req_align;
            q.address = req_address;
            expected_rsps.push_back(predict_alloc(q));
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               q = pending_reqs.pop_front();
               req_valid   <= 1'b1;
               req_op      <= q.op;
               req_size    <= q.size;
               req_align   <= q.align;
               req_address <= q.address;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor
   always @(posedge clock) begin
      alloc_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected transaction: status %0d address %h order %0d",
                        rsp_status, rsp_address_res, rsp_order);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_status !== e.status || rsp_address_res !== e.address ||
                rsp_order !== e.order) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %0d/%h/%0d got %0d/%h/%0d",
                           e.status, e.address, e.order,
                           rsp_status, rsp_address_res, rsp_order);
            end
         end
      end
   end

   function automatic logic [DATA_W-1:0] rand48();
      return DATA_W'({$urandom, $urandom});
   endfunction

   task automatic send(logic [1:0] op, logic [DATA_W-1:0] sz, logic [DATA_W-1:0] al,
                       logic [DATA_W-1:0] ad);
      alloc_req_type q;
      while (pending_reqs.size() != 0) @(negedge clock);
      if (sent_count < 340) begin
         send_idle_pct = 36;
         recv_idle_pct = 63;
      end else if (sent_count < 660) begin
         send_idle_pct = 63;
         recv_idle_pct = 36;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      q.op = op;
      q.size = sz;
      q.align = al;
      q.address = ad;
      pending_reqs.push_back(q);
      sent_count++;
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_regs(logic [5:0] h, logic [5:0] m, logic [DATA_W-1:0] b);
      drain();
      repeat (100) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= bba_pkg::CSR_HEAP_ORDER;
      csr_wdata <= DATA_W'(h);
      cfg_heap_order = h;
      clear_heap();
      @(posedge clock);
      csr_index <= bba_pkg::CSR_MIN_ORDER;
      csr_wdata <= DATA_W'(m);
      cfg_min_order = m;
      clear_heap();
      @(posedge clock);
      csr_index <= bba_pkg::CSR_HEAP_BASE;
      csr_wdata <= b;
      cfg_heap_base = b;
      clear_heap();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_random();
      int unsigned       pick, k, hmax;
      logic [DATA_W-1:0] sz, al, ad;
      hmax = (cfg_heap_order + 1 > 47) ? 47 : cfg_heap_order + 1;
      k    = $urandom_range(0, hmax);
      sz   = ($urandom_range(19) == 0) ? rand48() : rand48() & ((48'd1 << k) - 48'd1);
      pick = $urandom_range(9);
      al   = (pick == 0) ? '0 : (pick == 1) ? rand48() : 48'd1 << $urandom_range(0, hmax);
      pick = $urandom_range(19);
      if (pick < 13 && live_blocks.size() != 0)
         ad = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
      else if (pick < 16)
         ad = cfg_heap_base + (rand48() << eff_min_order()) % (48'd1 << cfg_heap_order);
      else if (pick < 18)
         ad = rand48();
      else
         ad = cfg_heap_base + 48'($urandom_range(1, 200));
      pick = $urandom_range(99);
      if (pick < 42) send(bba_pkg::OP_ALLOC, sz, rand48(), rand48());
      else if (pick < 82) send(bba_pkg::OP_FREE, rand48(), rand48(), ad);
      else if (pick < 95) send(bba_pkg::OP_ALIGN_ALLOC, sz, al, rand48());
      else send(2'd3, sz, al, rand48());
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = bba_pkg::CSR_HEAP_ORDER;
      csr_wdata      = '0;
      send_idle_pct  = 36;
      recv_idle_pct  = 63;
      mismatch_count = 0;
      sent_count     = 0;
      cfg_heap_order = 6'd20;
      cfg_min_order  = 6'd7;
      cfg_heap_base  = '0;
      clear_heap();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: defaults, heap of 2^20 with 1 KiB smallest blocks
      send(bba_pkg::OP_ALLOC, '0, '0, '0);
      send(bba_pkg::OP_ALLOC, '1, '0, '0);
      send(bba_pkg::OP_ALLOC, 48'd1 << 20, '0, '0);
      send(bba_pkg::OP_ALIGN_ALLOC, 48'd64, '0, '0);
      send(bba_pkg::OP_ALIGN_ALLOC, 48'd64, 48'd3, '0);
      send(bba_pkg::OP_ALIGN_ALLOC, 48'd1, 48'd1 << 47, '0);
      send(bba_pkg::OP_ALIGN_ALLOC, 48'd5, 48'd4096, '0);
      send(2'd3, 48'd100, 48'd256, '0);
      send(bba_pkg::OP_ALIGN_ALLOC, '0, 48'd1, '0);
      send(bba_pkg::OP_FREE, '0, '0, rand48());
      send(bba_pkg::OP_FREE, '0, '0, 48'h201);
      send(bba_pkg::OP_FREE, '0, '0, 48'd1 << 20);
      send(bba_pkg::OP_FREE, '0, '0, '1);
      drain();
      send(bba_pkg::OP_FREE, '0, '0, live_blocks[0]);
      send(bba_pkg::OP_FREE, '0, '0, live_blocks[0]);
      send(bba_pkg::OP_ALLOC, 48'd1 << 19, '0, '0);
      send(bba_pkg::OP_ALLOC, 48'd1 << 19, '0, '0);
      send(bba_pkg::OP_ALLOC, 48'd1 << 19, '0, '0);
      drain();
      while (live_blocks.size() != 0) begin
         send(bba_pkg::OP_FREE, '0, '0, live_blocks[0]);
         drain();
      end
      send(bba_pkg::OP_ALLOC, 48'd1 << 20, '0, '0);

      // register index with no register behind it: leaves the heap as it is
      drain();
      repeat (100) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= 2'd3;
      csr_wdata <= '1;
      @(posedge clock);
      csr_we <= 1'b0;
      send(bba_pkg::OP_ALLOC, 48'd1, '0, '0);

      write_regs(6'd12, 6'd4, rand48());
      repeat (200) send_random();
      // hold the sender until the block has answered everything
      drain();
      repeat (200) send_random();
      write_regs(6'd47, 6'd0, '1);
      repeat (150) send_random();
      write_regs(6'd5, 6'd7, rand48());
      repeat (40) send_random();
      write_regs(6'd0, 6'd0, '0);
      repeat (40) send_random();
      write_regs(6'd10, 6'd0, rand48());
      repeat (240) send_random();
      write_regs(6'd47, 6'd47, rand48());
      repeat (80) send_random();

      drain();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("simulation failed");
      $finish;
   end

endmodule
